// ----- hdl/mbe_pkg.sv -----
// Shared types and constants for the escape-time pixel block.
`timescale 1ns / 1ps
package mbe_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_X_LOW          = 3'd0;
  localparam logic [2:0] REG_X_HIGH         = 3'd1;
  localparam logic [2:0] REG_Y_LOW          = 3'd2;
  localparam logic [2:0] REG_Y_HIGH         = 3'd3;
  localparam logic [2:0] REG_MAX_ITERATIONS = 3'd4;
  localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd5;
  localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd6;

  // Register reset values
  localparam logic signed [31:0] RST_X_LOW  = -32'sd50331648;
  localparam logic signed [31:0] RST_X_HIGH = 32'sd16777216;
  localparam logic signed [31:0] RST_Y_LOW  = -32'sd33554432;
  localparam logic signed [31:0] RST_Y_HIGH = 32'sd33554432;
  localparam logic [15:0]        RST_MAX_ITERATIONS = 16'd500;
  localparam logic [12:0]        RST_IMAGE_WIDTH    = 13'd640;
  localparam logic [12:0]        RST_IMAGE_HEIGHT   = 13'd480;

  // Divider sizes
  localparam int DIV_N_W   = 44;
  localparam int DIV_D_W   = 16;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_N_W - 1);

  // Operand select for the shared divider
  typedef enum logic [1:0] {
    SEL_X,
    SEL_Y,
    SEL_GRAY
  } mbe_sel_t;

  typedef struct packed {
    logic     capture;
    logic     prod_load;
    logic     div_start;
    logic     coord_load;
    mbe_sel_t sel;
    logic     z_clear;
    logic     mul_load;
    logic     z_update;
    logic     gray_clear;
    logic     out_load;
  } mbe_cmd_t;

  typedef struct packed {
    logic div_done;
    logic at_limit;
    logic escaped;
    logic limit_zero;
  } mbe_sts_t;

endpackage

// ----- hdl/mbe_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mbe_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mbe_pkg::DIV_N_W-1:0]   dividend,
  input  logic [mbe_pkg::DIV_D_W-1:0]   divisor,
  output logic [mbe_pkg::DIV_N_W-1:0]   quotient,
  output logic                          done
);

  logic                            busy;
  logic [mbe_pkg::DIV_CNT_W-1:0]   count;
  logic [mbe_pkg::DIV_D_W-1:0]     rem;
  logic [mbe_pkg::DIV_N_W-1:0]     quo;
  logic [mbe_pkg::DIV_D_W-1:0]     den;
  logic [mbe_pkg::DIV_D_W:0]       trial;
  logic [mbe_pkg::DIV_D_W:0]       diff;
  logic                            fit;

  always_comb begin
    trial = {rem, quo[mbe_pkg::DIV_N_W-1]};
    diff  = trial - {1'b0, den};
    fit   = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (count == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (count == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend;
      den   <= divisor;
      rem   <= '0;
      count <= mbe_pkg::DIV_LAST;
    end else if (busy) begin
      rem   <= fit ? diff[mbe_pkg::DIV_D_W-1:0] : trial[mbe_pkg::DIV_D_W-1:0];
      quo   <= {quo[mbe_pkg::DIV_N_W-2:0], fit};
      count <= count - 1'b1;
    end
  end

  assign quotient = quo;

endmodule

// ----- hdl/mbe_dp.sv -----
// Datapath: view registers, coordinate mapping, iteration step and gray scaling.
`timescale 1ns / 1ps
module mbe_dp #(
  parameter int FRAC_BITS = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [11:0]       column,
  input  logic [11:0]       row,
  input  mbe_pkg::mbe_cmd_t cmd,
  output mbe_pkg::mbe_sts_t sts,
  output logic [15:0]       iterations,
  output logic [7:0]        gray_level
);

  localparam logic [63:0] BOUND = 64'd16 << (2 * FRAC_BITS);

  logic signed [31:0] x_low, x_high, y_low, y_high;
  logic [15:0]        max_iterations;
  logic [12:0]        image_width, image_height;

  logic [11:0]        col_reg, row_reg;
  logic signed [45:0] prod, prod_next;
  logic signed [45:0] prod_mag;
  logic signed [32:0] span_x, span_y;
  logic [23:0]        gray_num;
  logic [15:0]        width_eff, height_eff;

  logic                            div_start;
  logic [mbe_pkg::DIV_N_W-1:0]     div_dividend;
  logic [mbe_pkg::DIV_D_W-1:0]     div_divisor;
  logic [mbe_pkg::DIV_N_W-1:0]     div_quotient;
  logic                            div_done;

  logic signed [45:0] q_signed;
  logic signed [31:0] lo_sel;
  logic signed [46:0] coord_sum;
  logic signed [31:0] coord_sat;
  logic signed [31:0] cr, ci;

  logic signed [31:0] zr, zi;
  logic [15:0]        iter;
  logic signed [63:0] rr, ii, ri;
  logic signed [63:0] diff_ri;
  logic signed [63:0] zr_sum, zi_sum;
  logic [63:0]        mag_sum;
  logic [7:0]         gray_reg;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    if (v[63:31] == {33{v[63]}}) begin
      return v[31:0];
    end
    return v[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_low          <= mbe_pkg::RST_X_LOW;
      x_high         <= mbe_pkg::RST_X_HIGH;
      y_low          <= mbe_pkg::RST_Y_LOW;
      y_high         <= mbe_pkg::RST_Y_HIGH;
      max_iterations <= mbe_pkg::RST_MAX_ITERATIONS;
      image_width    <= mbe_pkg::RST_IMAGE_WIDTH;
      image_height   <= mbe_pkg::RST_IMAGE_HEIGHT;
    end else if (cfg_wen) begin
      case (cfg_index)
        mbe_pkg::REG_X_LOW:          x_low          <= cfg_data;
        mbe_pkg::REG_X_HIGH:         x_high         <= cfg_data;
        mbe_pkg::REG_Y_LOW:          y_low          <= cfg_data;
        mbe_pkg::REG_Y_HIGH:         y_high         <= cfg_data;
        mbe_pkg::REG_MAX_ITERATIONS: max_iterations <= cfg_data[15:0];
        mbe_pkg::REG_IMAGE_WIDTH:    image_width    <= cfg_data[12:0];
        mbe_pkg::REG_IMAGE_HEIGHT:   image_height   <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    span_x     = {x_high[31], x_high} - {x_low[31], x_low};
    span_y     = {y_high[31], y_high} - {y_low[31], y_low};
    gray_num   = {iter, 8'd0} - {8'd0, iter};
    width_eff  = (image_width == '0) ? 16'd1 : {3'd0, image_width};
    height_eff = (image_height == '0) ? 16'd1 : {3'd0, image_height};
    case (cmd.sel)
      mbe_pkg::SEL_X: begin
        prod_next   = $signed({1'b0, col_reg}) * span_x;
        div_divisor = width_eff;
        lo_sel      = x_low;
      end
      mbe_pkg::SEL_Y: begin
        prod_next   = $signed({1'b0, row_reg}) * span_y;
        div_divisor = height_eff;
        lo_sel      = y_low;
      end
      mbe_pkg::SEL_GRAY: begin
        prod_next   = $signed({22'd0, gray_num});
        div_divisor = max_iterations;
        lo_sel      = '0;
      end
      default: begin
        prod_next   = '0;
        div_divisor = 16'd1;
        lo_sel      = '0;
      end
    endcase
    prod_mag     = prod[45] ? -prod : prod;
    div_dividend = prod_mag[mbe_pkg::DIV_N_W-1:0];
    div_start    = cmd.div_start;
    q_signed     = prod[45] ? -$signed({2'b00, div_quotient})
                            : $signed({2'b00, div_quotient});
    coord_sum    = {{15{lo_sel[31]}}, lo_sel} + {q_signed[45], q_signed};
    coord_sat    = sat64({{17{coord_sum[46]}}, coord_sum});
  end

  mbe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  always_comb begin
    diff_ri = rr - ii;
    zr_sum  = (diff_ri >>> FRAC_BITS) + $signed({{32{cr[31]}}, cr});
    zi_sum  = (ri >>> (FRAC_BITS - 1)) + $signed({{32{ci[31]}}, ci});
    mag_sum = $unsigned(rr) + $unsigned(ii);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_reg <= column;
      row_reg <= row;
    end
    if (cmd.prod_load) begin
      prod <= prod_next;
    end
    if (cmd.coord_load) begin
      case (cmd.sel)
        mbe_pkg::SEL_X:    cr       <= coord_sat;
        mbe_pkg::SEL_Y:    ci       <= coord_sat;
        mbe_pkg::SEL_GRAY: gray_reg <= div_quotient[7:0];
        default: ;
      endcase
    end
    if (cmd.gray_clear) begin
      gray_reg <= '0;
    end
    if (cmd.z_clear) begin
      zr   <= '0;
      zi   <= '0;
      iter <= '0;
    end else if (cmd.z_update) begin
      zr   <= sat64(zr_sum);
      zi   <= sat64(zi_sum);
      iter <= iter + 1'b1;
    end
    if (cmd.mul_load) begin
      rr <= zr * zr;
      ii <= zi * zi;
      ri <= zr * zi;
    end
    if (cmd.out_load) begin
      iterations <= iter;
      gray_level <= gray_reg;
    end
  end

  always_comb begin
    sts.div_done   = div_done;
    sts.at_limit   = (iter == max_iterations);
    sts.escaped    = (mag_sum >= BOUND);
    sts.limit_zero = (max_iterations == '0);
  end

endmodule

// ----- hdl/mbe_ctrl.sv -----
// Controller: sequences mapping, iteration and gray scaling for one pixel.
`timescale 1ns / 1ps
module mbe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mbe_pkg::mbe_sts_t sts,
  output mbe_pkg::mbe_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROD_X,
    S_DIV_X,
    S_WAIT_X,
    S_PROD_Y,
    S_DIV_Y,
    S_WAIT_Y,
    S_MUL,
    S_UPD,
    S_PROD_G,
    S_DIV_G,
    S_WAIT_G,
    S_DONE
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    cmd.sel    = mbe_pkg::SEL_X;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_PROD_X;
        end
      end
      S_PROD_X: begin
        cmd.prod_load = 1'b1;
        state_next    = S_DIV_X;
      end
      S_DIV_X: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT_X;
      end
      S_WAIT_X: begin
        if (sts.div_done) begin
          cmd.coord_load = 1'b1;
          state_next     = S_PROD_Y;
        end
      end
      S_PROD_Y: begin
        cmd.sel       = mbe_pkg::SEL_Y;
        cmd.prod_load = 1'b1;
        state_next    = S_DIV_Y;
      end
      S_DIV_Y: begin
        cmd.sel       = mbe_pkg::SEL_Y;
        cmd.div_start = 1'b1;
        state_next    = S_WAIT_Y;
      end
      S_WAIT_Y: begin
        cmd.sel = mbe_pkg::SEL_Y;
        if (sts.div_done) begin
          cmd.coord_load = 1'b1;
          cmd.z_clear    = 1'b1;
          state_next     = S_MUL;
        end
      end
      S_MUL: begin
        if (sts.at_limit) begin
          state_next = S_PROD_G;
        end else begin
          cmd.mul_load = 1'b1;
          state_next   = S_UPD;
        end
      end
      S_UPD: begin
        if (sts.escaped) begin
          state_next = S_PROD_G;
        end else begin
          cmd.z_update = 1'b1;
          state_next   = S_MUL;
        end
      end
      S_PROD_G: begin
        cmd.sel = mbe_pkg::SEL_GRAY;
        if (sts.limit_zero) begin
          cmd.gray_clear = 1'b1;
          state_next     = S_DONE;
        end else begin
          cmd.prod_load = 1'b1;
          state_next    = S_DIV_G;
        end
      end
      S_DIV_G: begin
        cmd.sel       = mbe_pkg::SEL_GRAY;
        cmd.div_start = 1'b1;
        state_next    = S_WAIT_G;
      end
      S_WAIT_G: begin
        cmd.sel = mbe_pkg::SEL_GRAY;
        if (sts.div_done) begin
          cmd.coord_load = 1'b1;
          state_next     = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/mandelbrot_escape_pixel.sv -----
// Top level of the Mandelbrot escape-time pixel evaluator.
`timescale 1ns / 1ps
// Takes one pixel (column, row) per transfer and returns its escape count and
// gray level. One pixel is in work at a time. Each escape step loads the three
// 32x32 products, then makes the escape test and the update of z, and the two
// coordinate divisions and the gray division each go through the shared
// bit-serial divider at one quotient bit per cycle; the gray division is
// skipped when the limit is zero. The result sits in an output register, so a
// new pixel is accepted while the last result waits. The view registers may be
// written only while the block is idle.
module mandelbrot_escape_pixel #(
  parameter int FRAC_BITS = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] column,
  input  logic [11:0] row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] iterations,
  output logic [7:0]  gray_level
);

  mbe_pkg::mbe_cmd_t cmd;
  mbe_pkg::mbe_sts_t sts;

  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mbe_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .column     (column),
    .row        (row),
    .cmd        (cmd),
    .sts        (sts),
    .iterations (iterations),
    .gray_level (gray_level)
  );

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a pixel is in work");

  a_gray_zero_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (iterations != 16'd0 || gray_level == 8'd0))
    else $error("nonzero gray level for a zero count");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised without a pixel in work");

endmodule

// ----- verif/mandelbrot_escape_pixel_tb.sv -----
// Self-checking testbench for the escape-time pixel block: directed corners and random views.
`timescale 1ns / 1ps
module mandelbrot_escape_pixel_tb;

  localparam int FRAC = 25;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned LONG_HOLD_CYCLES = 3000;
  localparam int unsigned TAIL_CYCLES = 400;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PIXELS_PER_PHASE = 100;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam logic [63:0] ESCAPE_BOUND = 64'd16 << (2 * FRAC);
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam logic signed [31:0] ONE = 32'sd33554432;

  typedef struct {
    logic signed [31:0] x_low;
    logic signed [31:0] x_high;
    logic signed [31:0] y_low;
    logic signed [31:0] y_high;
    logic [15:0]        max_iterations;
    logic [12:0]        image_width;
    logic [12:0]        image_height;
  } view_t;

  typedef struct {
    logic [15:0] iterations;
    logic [7:0]  gray_level;
  } pixel_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_wen;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [11:0] column;
  logic [11:0] row;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] iterations;
  logic [7:0]  gray_level;

  view_t         view;
  pixel_result_t expected_pixels[$];
  pixel_result_t oldest;
  int unsigned   burst_left = 0;
  int unsigned   pixels_sent = 0;
  int unsigned   results_checked = 0;
  int unsigned   views_loaded = 0;
  int unsigned   fail_count = 0;
  int unsigned   cycle_count = 0;
  bit            long_hold = 1'b0;

  mandelbrot_escape_pixel #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .column    (column),
    .row       (row),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .iterations(iterations),
    .gray_level(gray_level)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic longint clamp32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint axis_point(input logic signed [31:0] lo, hi,
                                        input logic [11:0] pos, input logic [12:0] size);
    longint lo64;
    longint span;
    longint n;
    lo64 = lo;
    span = longint'(hi) - lo64;
    n = (size == 13'd0) ? 64'sd1 : longint'(size);
    return clamp32(lo64 + (longint'(pos) * span) / n);
  endfunction

  function automatic pixel_result_t escape_pixel(input logic [11:0] px, input logic [11:0] py);
    pixel_result_t res;
    longint        cr, ci, zr, zi, rr, ii, ri;
    logic [63:0]   mag;
    int unsigned   steps;
    bit            escaped;
    cr = axis_point(view.x_low, view.x_high, px, view.image_width);
    ci = axis_point(view.y_low, view.y_high, py, view.image_height);
    zr = 0;
    zi = 0;
    steps = 0;
    escaped = 1'b0;
    while (!escaped && steps < view.max_iterations) begin
      rr = zr * zr;
      ii = zi * zi;
      ri = zr * zi;
      mag = rr + ii;
      if (mag >= ESCAPE_BOUND) begin
        escaped = 1'b1;
      end else begin
        zr = clamp32(((rr - ii) >>> FRAC) + cr);
        zi = clamp32((ri >>> (FRAC - 1)) + ci);
        steps++;
      end
    end
    res.iterations = 16'(steps);
    res.gray_level = (view.max_iterations == 16'd0) ? 8'd0 :
                     8'((255 * steps) / view.max_iterations);
    return res;
  endfunction

  function automatic view_t reset_view();
    view_t v;
    v.x_low = mbe_pkg::RST_X_LOW;
    v.x_high = mbe_pkg::RST_X_HIGH;
    v.y_low = mbe_pkg::RST_Y_LOW;
    v.y_high = mbe_pkg::RST_Y_HIGH;
    v.max_iterations = mbe_pkg::RST_MAX_ITERATIONS;
    v.image_width = mbe_pkg::RST_IMAGE_WIDTH;
    v.image_height = mbe_pkg::RST_IMAGE_HEIGHT;
    return v;
  endfunction

  function automatic logic [12:0] random_size();
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick == 0) return 13'd0;
    if (pick == 1) return 13'd4096;
    if (pick == 2) return 13'($urandom_range(8191, 4097));
    return 13'($urandom_range(64, 1));
  endfunction

  function automatic view_t random_view();
    view_t              v;
    logic signed [31:0] swap;
    int unsigned        kind;
    kind = $urandom_range(9);
    if (kind < 6) begin
      v.x_low = -32'sd1 * 32'($urandom_range(83886080, 8388608));
      v.x_high = v.x_low + 32'($urandom_range(134217728, 8388608));
      v.y_low = -32'sd1 * 32'($urandom_range(50331648, 4194304));
      v.y_high = v.y_low + 32'($urandom_range(100663296, 8388608));
      if ($urandom_range(9) == 0) begin
        swap = v.x_low;
        v.x_low = v.x_high;
        v.x_high = swap;
      end
    end else if (kind < 8) begin
      v.x_low = 32'($urandom_range(83886080, 0)) - 32'sd67108864;
      v.x_high = v.x_low + (32'sd1 <<< $urandom_range(20, 4));
      v.y_low = 32'($urandom_range(67108864, 0)) - ONE;
      v.y_high = v.y_low + (32'sd1 <<< $urandom_range(20, 4));
    end else begin
      v.x_low = $urandom;
      v.x_high = $urandom;
      v.y_low = $urandom;
      v.y_high = $urandom;
    end
    v.image_width = random_size();
    v.image_height = random_size();
    v.max_iterations = mbe_pkg::RST_MAX_ITERATIONS;
    return v;
  endfunction

  function automatic logic [11:0] pick_position(input logic [12:0] size);
    int unsigned span;
    if ($urandom_range(9) < 2) return 12'($urandom);
    span = (size == 13'd0) ? 1 : ((size > 13'd4096) ? 4096 : int'(size));
    return 12'($urandom_range(span - 1, 0));
  endfunction

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  task automatic apply_view(input view_t v);
    cfg_wen <= 1'b1;
    cfg_index <= mbe_pkg::REG_X_LOW;
    cfg_data <= v.x_low;
    @(posedge clk);
    cfg_index <= mbe_pkg::REG_X_HIGH;
    cfg_data <= v.x_high;
    @(posedge clk);
    cfg_index <= mbe_pkg::REG_Y_LOW;
    cfg_data <= v.y_low;
    @(posedge clk);
    cfg_index <= mbe_pkg::REG_Y_HIGH;
    cfg_data <= v.y_high;
    @(posedge clk);
    cfg_index <= mbe_pkg::REG_MAX_ITERATIONS;
    cfg_data <= 32'(v.max_iterations);
    @(posedge clk);
    cfg_index <= mbe_pkg::REG_IMAGE_WIDTH;
    cfg_data <= 32'(v.image_width);
    @(posedge clk);
    cfg_index <= mbe_pkg::REG_IMAGE_HEIGHT;
    cfg_data <= 32'(v.image_height);
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data <= $urandom;
    @(posedge clk);
    cfg_wen <= 1'b0;
    view = v;
    views_loaded++;
  endtask

  task automatic send_pixel(input logic [11:0] px, input logic [11:0] py);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(12, 0);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(100, 40) : $urandom_range(16, 1);
    end
    burst_left--;
    column <= px;
    row <= py;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    expected_pixels.push_back(escape_pixel(px, py));
    pixels_sent++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      results_checked++;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: iterations %0d, gray_level %0d", iterations, gray_level);
        fail_count++;
      end else begin
        oldest = expected_pixels.pop_front();
        if (iterations !== oldest.iterations) begin
          $error("iterations: expected %0d, actual %0d", oldest.iterations, iterations);
          fail_count++;
        end
        if (gray_level !== oldest.gray_level) begin
          $error("gray_level: expected %0d, actual %0d", oldest.gray_level, gray_level);
          fail_count++;
        end
      end
    end
  end

  initial begin : result_sink
    int unsigned mode_left;
    int unsigned ready_pct;
    int unsigned held;
    out_ready <= 1'b0;
    mode_left = 0;
    ready_pct = 100;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        for (held = 0; held < LONG_HOLD_CYCLES; held++) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(300, 20);
          case ($urandom_range(3))
            0: ready_pct = 100;
            1: ready_pct = 70;
            2: ready_pct = 30;
            default: ready_pct = 5;
          endcase
        end
        mode_left--;
        out_ready <= ($urandom_range(99) < ready_pct);
      end
    end
  end

  task automatic test_reset_view();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd639, 12'd479);
    send_pixel(12'd480, 12'd240);
    send_pixel(12'd4095, 12'd4095);
  endtask

  task automatic test_zero_limit();
    view_t v;
    v = reset_view();
    v.max_iterations = 16'd0;
    wait_for_results();
    apply_view(v);
    send_pixel(12'd480, 12'd240);
    send_pixel(12'd0, 12'd0);
  endtask

  task automatic test_full_limit();
    view_t v;
    v = reset_view();
    v.max_iterations = 16'hFFFF;
    wait_for_results();
    apply_view(v);
    send_pixel(12'd480, 12'd240);
    send_pixel(12'd0, 12'd0);
  endtask

  task automatic test_escape_bound();
    view_t v;
    v.x_low = 4 * ONE - 1;
    v.x_high = 4 * ONE;
    v.y_low = '0;
    v.y_high = '0;
    v.max_iterations = 16'd3;
    v.image_width = 13'd1;
    v.image_height = 13'd1;
    wait_for_results();
    apply_view(v);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd2, 12'd4095);
  endtask

  task automatic test_view_edges();
    view_t v;
    v.x_low = 32'sh8000_0000;
    v.x_high = 32'sh7FFF_FFFF;
    v.y_low = 32'sh7FFF_FFFF;
    v.y_high = 32'sh8000_0000;
    v.max_iterations = 16'd7;
    v.image_width = 13'd0;
    v.image_height = 13'd0;
    wait_for_results();
    apply_view(v);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd4095, 12'd0);
    v.x_low = 32'sd1;
    v.x_high = 32'sd0;
    v.y_low = 32'sd0;
    v.y_high = -32'sd2;
    v.max_iterations = 16'd2;
    v.image_width = 13'd3;
    v.image_height = 13'd8191;
    wait_for_results();
    apply_view(v);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd2, 12'd4095);
    send_pixel(12'd4095, 12'd8);
  endtask

  task automatic test_backpressure();
    view_t v;
    v = reset_view();
    v.max_iterations = 16'd20;
    wait_for_results();
    apply_view(v);
    long_hold = 1'b1;
    repeat (6) send_pixel(pick_position(v.image_width), pick_position(v.image_height));
    wait_for_results();
    repeat (2) send_pixel(pick_position(v.image_width), pick_position(v.image_height));
  endtask

  task automatic test_random_views();
    view_t       v;
    int unsigned phase;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      v = random_view();
      v.max_iterations = (phase % 4 == 3) ? 16'($urandom_range(300, 100)) :
                                            16'($urandom_range(40, 0));
      wait_for_results();
      apply_view(v);
      repeat (PIXELS_PER_PHASE) begin
        send_pixel(pick_position(v.image_width), pick_position(v.image_height));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_wen <= 1'b0;
    cfg_index <= mbe_pkg::REG_X_LOW;
    cfg_data <= '0;
    in_valid <= 1'b0;
    column <= '0;
    row <= '0;
    view = reset_view();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_view();
    test_zero_limit();
    test_full_limit();
    test_escape_bound();
    test_view_edges();
    test_backpressure();
    test_random_views();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d pixels over %0d view settings in %0d cycles", pixels_sent,
             views_loaded + 1, cycle_count);
    $display("Checked %0d results, %0d mismatches", results_checked, fail_count);
    if (fail_count == 0 && expected_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- mandelbrot_escape_pixel.f -----
hdl/mbe_pkg.sv
hdl/mbe_div.sv
hdl/mbe_dp.sv
hdl/mbe_ctrl.sv
hdl/mandelbrot_escape_pixel.sv
verif/mandelbrot_escape_pixel_tb.sv
